### sv/swmx_pkg.sv
// ----------------------------------------------------------------------------
// swmx_pkg
// Shared types and constants of the sliding window minimum block.
// ----------------------------------------------------------------------------
package swmx_pkg;

	// Width of the arrival tag of each sample; tags wrap modulo 2^POS_WIDTH.
	localparam int unsigned POS_WIDTH = 32;

	// Width of the reported minimum and of the running XOR.
	localparam int unsigned OUT_WIDTH = 32;

	// Width of the window length register.
	localparam int unsigned WLEN_WIDTH = 11;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXP   = 5'b00010,
		ST_POP   = 5'b00100,
		ST_APP   = 5'b01000,
		ST_FRONT = 5'b10000
	} swmx_state_t;

endpackage

### sv/swmx_qram.sv
// ----------------------------------------------------------------------------
// swmx_qram
// Queue storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module swmx_qram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10,
	parameter int unsigned DW    = 64
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// The read port may also address slots outside the live queue, such as the head of an empty queue.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### sv/sliding_window_minimum_xor.sv
// ----------------------------------------------------------------------------
// sliding_window_minimum_xor
// Each sample accepted in IDLE first expires old front entries (EXP), then
// pops larger entries off the back (POP), is appended (APP) and gives its
// result in FRONT, which waits while the result register is occupied. No new
// sample is accepted until then; the queue memory has one registered read port.
// Reset: asynchronous, active low; the queue is empty, the window length is 1.
// ----------------------------------------------------------------------------
module sliding_window_minimum_xor #(
	parameter int unsigned WINDOW_MAX   = 1024,
	parameter int unsigned SAMPLE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// Configuration: window length, written whenever cfg_we is high.
	input  logic                                cfg_we,
	input  logic [swmx_pkg::WLEN_WIDTH-1:0]     cfg_wdata,

	// Sample input channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SAMPLE_WIDTH-1:0]             sample,

	// Result channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                window_full,
	output logic [swmx_pkg::OUT_WIDTH-1:0]      window_min,
	output logic [swmx_pkg::OUT_WIDTH-1:0]      xor_total
);

	// Address width of the ring and width of a count that can hold WINDOW_MAX.
	localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
	localparam int unsigned PW = swmx_pkg::POS_WIDTH;
	localparam int unsigned DW = PW + SAMPLE_WIDTH;

	// Ring slot of the entry that lies off places behind the head.
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(off);
		if (s >= (CW+1)'(WINDOW_MAX)) begin
			s = s - (CW+1)'(WINDOW_MAX);
		end
		return s[AW-1:0];
	endfunction

	swmx_pkg::swmx_state_t state_q, state_nx;

	logic [swmx_pkg::WLEN_WIDTH-1:0] wlen_q;
	logic [AW-1:0]                   head_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   arrived_q;
	logic [PW-1:0]                   pos_q;
	logic [swmx_pkg::OUT_WIDTH-1:0]  xor_q;
	logic [SAMPLE_WIDTH-1:0]         val_q;
	logic                            was_empty_q;

	logic                            out_valid_q;
	logic                            window_full_q;
	logic [swmx_pkg::OUT_WIDTH-1:0]  window_min_q;
	logic [swmx_pkg::OUT_WIDTH-1:0]  xor_total_q;

	// Memory interface.
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] wr_data;
	logic [AW-1:0] rd_addr;
	logic [DW-1:0] rd_data;

	logic [SAMPLE_WIDTH-1:0] rd_val;
	logic [PW-1:0]           rd_pos;

	assign rd_val = rd_data[SAMPLE_WIDTH-1:0];
	assign rd_pos = rd_data[DW-1:SAMPLE_WIDTH];

	// Effective window: a length of zero acts as one, and anything above the
	// queue capacity saturates to the capacity.
	logic [CW-1:0] win;
	always_comb begin
		if (wlen_q == '0) begin
			win = CW'(1);
		end else if (32'(wlen_q) > 32'(WINDOW_MAX)) begin
			win = CW'(WINDOW_MAX);
		end else begin
			win = CW'(wlen_q);
		end
	end

	// The front entry has left the window when its age reaches the length.
	// Ages are taken modulo 2^PW, which is exact since no entry outlives the
	// window.
	logic expire;
	logic greater;
	assign expire  = (pos_q - rd_pos) >= PW'(win);
	assign greater = rd_val > val_q;

	// The guard below never fires in practice: expiry leaves at most
	// window - 1 entries before the append.
	logic          guard;
	logic [AW-1:0] app_head;
	logic [CW-1:0] count_m1;
	logic [CW-1:0] count_m2;
	assign guard    = (count_q == CW'(WINDOW_MAX));
	assign app_head = guard ? slot(head_q, CW'(1)) : head_q;
	assign count_m1 = count_q - CW'(1);
	assign count_m2 = count_q - CW'(2);

	// Result of the current sample.
	logic                           out_free;
	logic [CW-1:0]                  arrived_nx;
	logic                           full_nx;
	logic [SAMPLE_WIDTH-1:0]        front_val;
	logic [swmx_pkg::OUT_WIDTH-1:0] min_nx;
	assign out_free   = !out_valid_q || out_ready;
	assign arrived_nx = (arrived_q < CW'(WINDOW_MAX)) ? arrived_q + CW'(1) : arrived_q;
	assign full_nx    = arrived_nx >= win;
	// A sample appended to an empty queue is its own front; this also covers
	// the write to the head slot in the same cycle as its read.
	assign front_val  = was_empty_q ? val_q : rd_val;
	assign min_nx     = full_nx ? swmx_pkg::OUT_WIDTH'(front_val) : '0;

	assign in_ready = (state_q == swmx_pkg::ST_IDLE);

	// Sequencer and read address. Each state that compares an entry issues the
	// read for the next one in the same cycle.
	always_comb begin
		state_nx = state_q;
		rd_addr  = head_q;
		wr_en    = 1'b0;
		wr_addr  = slot(head_q, count_q);
		wr_data  = {pos_q, val_q};
		unique case (state_q)
			swmx_pkg::ST_IDLE: begin
				// Read the front for the expiry check of the incoming sample.
				rd_addr = head_q;
				if (in_valid) begin
					state_nx = (count_q == '0) ? swmx_pkg::ST_APP : swmx_pkg::ST_EXP;
				end
			end
			swmx_pkg::ST_EXP: begin
				if (expire) begin
					rd_addr  = slot(head_q, CW'(1));
					state_nx = (count_q == CW'(1)) ? swmx_pkg::ST_APP : swmx_pkg::ST_EXP;
				end else begin
					// Front stays; start on the back of the queue.
					rd_addr  = slot(head_q, count_m1);
					state_nx = swmx_pkg::ST_POP;
				end
			end
			swmx_pkg::ST_POP: begin
				rd_addr = slot(head_q, count_m2);
				if (greater) begin
					state_nx = (count_q == CW'(1)) ? swmx_pkg::ST_APP : swmx_pkg::ST_POP;
				end else begin
					state_nx = swmx_pkg::ST_APP;
				end
			end
			swmx_pkg::ST_APP: begin
				wr_en    = 1'b1;
				rd_addr  = app_head;
				state_nx = swmx_pkg::ST_FRONT;
			end
			swmx_pkg::ST_FRONT: begin
				// Hold the front address so the read data stays put while the
				// result register is still occupied.
				rd_addr = head_q;
				if (out_free) begin
					state_nx = swmx_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = swmx_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swmx_pkg::ST_IDLE;
			wlen_q      <= swmx_pkg::WLEN_WIDTH'(1);
			head_q      <= '0;
			count_q     <= '0;
			arrived_q   <= '0;
			pos_q       <= '0;
			xor_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				wlen_q <= cfg_wdata;
			end
			case (state_q)
				swmx_pkg::ST_EXP: begin
					if (expire) begin
						head_q  <= slot(head_q, CW'(1));
						count_q <= count_m1;
					end
				end
				swmx_pkg::ST_POP: begin
					if (greater) begin
						count_q <= count_m1;
					end
				end
				swmx_pkg::ST_APP: begin
					head_q <= app_head;
					if (!guard) begin
						count_q <= count_q + CW'(1);
					end
				end
				swmx_pkg::ST_FRONT: begin
					if (out_free) begin
						pos_q     <= pos_q + PW'(1);
						arrived_q <= arrived_nx;
						if (full_nx) begin
							xor_q <= xor_q ^ min_nx;
						end
					end
				end
				default: begin
				end
			endcase
			// The result register is loaded as soon as it is free or being
			// emptied by a transfer in the same cycle.
			if (state_q == swmx_pkg::ST_FRONT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the sample being worked on and of the result.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			val_q <= sample;
		end
		if (state_q == swmx_pkg::ST_APP) begin
			was_empty_q <= (count_q == '0);
		end
		if (state_q == swmx_pkg::ST_FRONT && out_free) begin
			window_full_q <= full_nx;
			window_min_q  <= min_nx;
			xor_total_q   <= full_nx ? (xor_q ^ min_nx) : xor_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign window_full = window_full_q;
	assign window_min  = window_min_q;
	assign xor_total   = xor_total_q;

	// The monotonic queue: value and arrival tag of each candidate minimum.
	swmx_qram #(
		.DEPTH(WINDOW_MAX),
		.AW   (AW),
		.DW   (DW)
	) u_qram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule
